// File: design/sv39_page_table_walker_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Sv39 page table walker
// Clocked implication checks with synchronous active-low reset disable.
// ----------------------------------------------------------------------------
`ifndef SV39_PAGE_TABLE_WALKER_UNIT_ASSERT_SVH
`define SV39_PAGE_TABLE_WALKER_UNIT_ASSERT_SVH

// same-cycle implication
`define SV39PTW_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SV39PTW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/sv39ptw_pkg.sv
// ----------------------------------------------------------------------------
// Sv39 page table walker package
// Widths, codes and payload types shared by the walker modules.
// ----------------------------------------------------------------------------
package sv39ptw_pkg;

  localparam int LEVELS     = 3;
  localparam int IDX_W      = 9;
  localparam int PAGE_SHIFT = 12;
  localparam int PPN_W      = 44;
  localparam int ADDR_W     = 56;
  localparam int DATA_W     = 64;
  localparam int VPN_W      = IDX_W * LEVELS;
  localparam int VA_TOP     = VPN_W + PAGE_SHIFT - 1;
  localparam int LEVEL_W    = (LEVELS > 2) ? $clog2(LEVELS) : 1;
  localparam int Q_DEPTH    = 2;
  localparam int Q_PTR_W    = $clog2(Q_DEPTH);
  localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

  localparam int PTE_V_BIT   = 0;
  localparam int PTE_U_BIT   = 4;
  localparam int PTE_PPN_LSB = 10;

  localparam logic OP_TRANSLATE = 1'b0;
  localparam logic OP_DATA      = 1'b1;

  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_RANGE     = 3'd1;
  localparam logic [2:0] ST_UPPER_INV = 3'd2;
  localparam logic [2:0] ST_LEAF_INV  = 3'd3;
  localparam logic [2:0] ST_NOT_USER  = 3'd4;

  typedef struct packed {
    logic              opcode;
    logic [DATA_W-1:0] virt_addr;
    logic [DATA_W-1:0] entry_data;
  } in_item_t;

  typedef struct packed {
    logic              result_kind;
    logic [ADDR_W-1:0] entry_addr;
    logic [2:0]        status;
    logic [ADDR_W-1:0] phys_page_addr;
  } out_item_t;

  typedef struct packed {
    logic             is_data;
    logic             fault;
    logic [VPN_W-1:0] vpn;
    logic [PPN_W-1:0] ppn;
    logic             pte_v;
    logic             pte_u;
  } q_item_t;

endpackage

// File: design/sv39ptw_front.sv
// ----------------------------------------------------------------------------
// Sv39 walker front end
// Accepts requests and classifies them into compact queue entries.
// ----------------------------------------------------------------------------
module sv39ptw_front (
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sv39ptw_pkg::in_item_t in_data,
  input  logic                 q_full,
  output logic                 q_push,
  output sv39ptw_pkg::q_item_t q_push_item
);
  import sv39ptw_pkg::*;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_push_item.is_data = (in_data.opcode == OP_DATA);
    q_push_item.fault   = |in_data.virt_addr[DATA_W-1:VA_TOP];
    q_push_item.vpn     = in_data.virt_addr[PAGE_SHIFT +: VPN_W];
    q_push_item.ppn     = in_data.entry_data[PTE_PPN_LSB +: PPN_W];
    q_push_item.pte_v   = in_data.entry_data[PTE_V_BIT];
    q_push_item.pte_u   = in_data.entry_data[PTE_U_BIT];
  end

endmodule

// File: design/sv39ptw_queue.sv
// ----------------------------------------------------------------------------
// Sv39 walker request queue
// Short FIFO of classified requests between front and back end.
// ----------------------------------------------------------------------------
module sv39ptw_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  sv39ptw_pkg::q_item_t push_item,
  output logic                 full,
  input  logic                 pop,
  output logic                 head_valid,
  output sv39ptw_pkg::q_item_t head_item
);
  import sv39ptw_pkg::*;

  q_item_t              mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0]   cnt_r, cnt_nxt;
  logic                 do_push, do_pop;

  assign full       = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_item  = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// File: design/sv39ptw_back.sv
// ----------------------------------------------------------------------------
// Sv39 walker back end
// Walk state machine and registered result stage.
// ----------------------------------------------------------------------------
`include "sv39_page_table_walker_unit_assert.svh"

module sv39ptw_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [sv39ptw_pkg::PPN_W-1:0] root_ppn,
  input  logic                          q_valid,
  input  sv39ptw_pkg::q_item_t          q_item,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_ready,
  output sv39ptw_pkg::out_item_t        out_data
);
  import sv39ptw_pkg::*;

  localparam logic [LEVEL_W-1:0] LEVEL_TOP = LEVEL_W'(LEVELS - 1);

  logic               busy_r, busy_nxt;
  logic [LEVEL_W-1:0] level_r, level_nxt;
  logic [VPN_W-1:0]   vpn_r, vpn_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_item_t          out_data_r, out_data_nxt;
  logic               out_free, take, emit;
  out_item_t          res;

  function automatic logic [IDX_W-1:0] vpn_index(input logic [VPN_W-1:0] vpn,
                                                 input logic [LEVEL_W-1:0] lvl);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < LEVELS; i++) begin
      if (lvl == LEVEL_W'(i)) idx = vpn[i*IDX_W +: IDX_W];
    end
    return idx;
  endfunction

  assign out_free  = !out_valid_r || out_ready;
  assign take      = q_valid && out_free;
  assign q_pop     = take;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    busy_nxt      = busy_r;
    level_nxt     = level_r;
    vpn_nxt       = vpn_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    emit          = 1'b0;
    res           = '0;
    if (take) begin
      if (!q_item.is_data) begin
        if (!busy_r) begin
          emit = 1'b1;
          if (q_item.fault) begin
            res.result_kind = KIND_DONE;
            res.status      = ST_RANGE;
          end else begin
            vpn_nxt         = q_item.vpn;
            level_nxt       = LEVEL_TOP;
            busy_nxt        = 1'b1;
            res.result_kind = KIND_READ;
            res.entry_addr  = {root_ppn, vpn_index(q_item.vpn, LEVEL_TOP), 3'b000};
          end
        end
      end else if (busy_r) begin
        emit = 1'b1;
        if (level_r != '0) begin
          if (!q_item.pte_v) begin
            res.result_kind = KIND_DONE;
            res.status      = ST_UPPER_INV;
          end else begin
            level_nxt       = level_r - 1'b1;
            res.result_kind = KIND_READ;
            res.entry_addr  = {q_item.ppn, vpn_index(vpn_r, level_r - 1'b1), 3'b000};
          end
        end else begin
          res.result_kind = KIND_DONE;
          if (!q_item.pte_v) begin
            res.status = ST_LEAF_INV;
          end else if (!q_item.pte_u) begin
            res.status = ST_NOT_USER;
          end else begin
            res.status         = ST_OK;
            res.phys_page_addr = {q_item.ppn, PAGE_SHIFT'(0)};
          end
        end
      end
      if (emit && res.result_kind == KIND_DONE) begin
        busy_nxt  = 1'b0;
        level_nxt = '0;
      end
    end
    if (out_free) begin
      out_valid_nxt = take && emit;
      if (take && emit) out_data_nxt = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      level_r     <= '0;
      vpn_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      level_r     <= level_nxt;
      vpn_r       <= vpn_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  `SV39PTW_ASSERT_NEXT(a_done_clears_busy, clk, rst_n,
    take && emit && res.result_kind == KIND_DONE, !busy_r, "walk still busy after done")
  `SV39PTW_ASSERT_IMPL(a_idle_level_zero, clk, rst_n,
    !busy_r, level_r == '0, "idle walker holds nonzero level")
  `SV39PTW_ASSERT_IMPL(a_read_while_busy, clk, rst_n,
    out_valid_r && out_data_r.result_kind == KIND_READ, busy_r, "read request without walk")
  `SV39PTW_ASSERT_IMPL(a_level_bound, clk, rst_n,
    busy_r, level_r <= LEVEL_TOP, "walk level out of range")

endmodule

// File: design/sv39_page_table_walker_unit.sv
// ----------------------------------------------------------------------------
// Sv39 page table walker
// Three-level walk: range check, entry read requests, leaf permission check.
// ----------------------------------------------------------------------------
//  channel  ports                        direction
//  in       in_valid/in_ready/in_data    requests: translate or table entry
//  out      out_valid/out_ready/out_data entry reads and finished translations
//  cfg      cfg_we/cfg_wdata             root table page number
//
//  One request per cycle while the queue has room; each passes the front
//  end, a two-entry queue and the walk stage, and out_valid comes from the
//  registered result stage.
//  The walk stage sets the rate: one queue entry retires per cycle while the
//  result register is free or being taken.
//  Synchronous active-low reset empties the queue and idles the walk.
//  A stalled result holds the walk stage; the queue absorbs two requests.
// ----------------------------------------------------------------------------
module sv39_page_table_walker_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [sv39ptw_pkg::PPN_W-1:0] cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  sv39ptw_pkg::in_item_t         in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output sv39ptw_pkg::out_item_t        out_data
);
  import sv39ptw_pkg::*;

  logic [PPN_W-1:0] root_ppn_r;
  logic             q_full, q_push, q_pop, q_valid;
  q_item_t          q_push_item, q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_ppn_r <= '0;
    end else if (cfg_we) begin
      root_ppn_r <= cfg_wdata;
    end
  end

  sv39ptw_front u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_push_item (q_push_item)
  );

  sv39ptw_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (q_push_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_item  (q_head)
  );

  sv39ptw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .root_ppn  (root_ppn_r),
    .q_valid   (q_valid),
    .q_item    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: bench/walk_checker.sv
// ----------------------------------------------------------------------------
// Sv39 walk checker
// Watches the request, result and root-register ports of the walker, predicts
// each result from its own copy of the walk state, and compares in order.
// ----------------------------------------------------------------------------
module walk_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [sv39ptw_pkg::PPN_W-1:0] cfg_wdata,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  sv39ptw_pkg::in_item_t         in_data,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  sv39ptw_pkg::out_item_t        out_data,
  output int unsigned                   errors,
  output int unsigned                   results_due,
  output int unsigned                   requests_seen,
  output int unsigned                   results_seen,
  output int unsigned                   walks_ok,
  output int unsigned                   walks_faulted
);
  import sv39ptw_pkg::*;

  logic             walking;
  logic [1:0]       level;
  logic [VPN_W-1:0] vpn_held;
  logic [PPN_W-1:0] root_ppn;
  out_item_t        due_results[$];

  function automatic logic [ADDR_W-1:0] table_entry_addr(input logic [PPN_W-1:0] ppn,
                                                          input logic [1:0] lvl);
    logic [VPN_W-1:0]  shifted;
    logic [ADDR_W-1:0] addr;
    shifted = vpn_held >> (lvl * IDX_W);
    addr = {ppn, {PAGE_SHIFT{1'b0}}};
    addr = addr + (ADDR_W'(shifted[IDX_W-1:0]) << 3);
    return addr;
  endfunction

  function automatic out_item_t entry_read(input logic [ADDR_W-1:0] addr);
    out_item_t res;
    res.result_kind    = KIND_READ;
    res.entry_addr     = addr;
    res.status         = ST_OK;
    res.phys_page_addr = '0;
    return res;
  endfunction

  function automatic out_item_t walk_done(input logic [2:0] st,
                                          input logic [ADDR_W-1:0] page);
    out_item_t res;
    res.result_kind    = KIND_DONE;
    res.entry_addr     = '0;
    res.status         = st;
    res.phys_page_addr = page;
    walking = 1'b0;
    level   = '0;
    return res;
  endfunction

  function automatic bit next_walk_result(input in_item_t req, output out_item_t res);
    logic [PPN_W-1:0] next_ppn;
    res = '0;
    next_ppn = req.entry_data[PTE_PPN_LSB +: PPN_W];
    if (req.opcode == OP_TRANSLATE) begin
      if (walking) return 1'b0;
      if (|req.virt_addr[DATA_W-1:VA_TOP]) begin
        res = walk_done(ST_RANGE, '0);
        return 1'b1;
      end
      vpn_held = req.virt_addr[PAGE_SHIFT +: VPN_W];
      level    = 2'(LEVELS - 1);
      walking  = 1'b1;
      res = entry_read(table_entry_addr(root_ppn, level));
      return 1'b1;
    end
    if (!walking) return 1'b0;
    if (level != 0) begin
      if (!req.entry_data[PTE_V_BIT]) begin
        res = walk_done(ST_UPPER_INV, '0);
      end else begin
        level = level - 2'd1;
        res = entry_read(table_entry_addr(next_ppn, level));
      end
    end else if (!req.entry_data[PTE_V_BIT]) begin
      res = walk_done(ST_LEAF_INV, '0);
    end else if (!req.entry_data[PTE_U_BIT]) begin
      res = walk_done(ST_NOT_USER, '0);
    end else begin
      res = walk_done(ST_OK, {next_ppn, {PAGE_SHIFT{1'b0}}});
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    bit        bad;
    if (!rst_n) begin
      walking       = 1'b0;
      level         = '0;
      vpn_held      = '0;
      root_ppn      = '0;
      errors        = 0;
      requests_seen = 0;
      results_seen  = 0;
      walks_ok      = 0;
      walks_faulted = 0;
      due_results.delete();
    end else begin
      if (cfg_we) root_ppn = cfg_wdata;
      if (out_valid && out_ready) begin
        results_seen++;
        if (due_results.size() == 0) begin
          if (errors < 10)
            $display("walk mismatch: unexpected result kind=%0d addr=%h st=%0d page=%h",
                     out_data.result_kind, out_data.entry_addr, out_data.status,
                     out_data.phys_page_addr);
          errors++;
        end else begin
          want = due_results.pop_front();
          bad = (out_data.result_kind !== want.result_kind) ||
                (out_data.entry_addr !== want.entry_addr) ||
                (out_data.status !== want.status) ||
                (out_data.phys_page_addr !== want.phys_page_addr);
          if (bad) begin
            if (errors < 10) begin
              $display("walk mismatch: expected kind=%0d addr=%h st=%0d page=%h",
                       want.result_kind, want.entry_addr, want.status, want.phys_page_addr);
              $display("               actual   kind=%0d addr=%h st=%0d page=%h",
                       out_data.result_kind, out_data.entry_addr, out_data.status,
                       out_data.phys_page_addr);
            end
            errors++;
          end
          if (want.result_kind == KIND_DONE) begin
            if (want.status == ST_OK) walks_ok++;
            else walks_faulted++;
          end
        end
      end
      if (in_valid && in_ready) begin
        requests_seen++;
        if (next_walk_result(in_data, want)) due_results.push_back(want);
      end
    end
    results_due <= due_results.size();
  end

endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// Sv39 page table walker testbench
// Drives translate and table-entry requests through three idling mixes and
// four root table settings, with one long result stall; a checker beside the
// walker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
  import sv39ptw_pkg::*;

  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int DRAIN_CYCLES    = 6;
  localparam int HOLD_OFF_CYCLES = 120;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [PPN_W-1:0] cfg_wdata;
  logic             in_valid;
  logic             in_ready;
  in_item_t         in_data;
  logic             out_valid;
  logic             out_ready;
  out_item_t        out_data;

  int unsigned in_gap_pct;
  int unsigned out_stall_pct;
  logic        hold_off_req;
  bit          hold_off_taken;
  int unsigned quiet_cycles;

  int unsigned errors;
  int unsigned results_due;
  int unsigned requests_seen;
  int unsigned results_seen;
  int unsigned walks_ok;
  int unsigned walks_faulted;

  sv39_page_table_walker_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  walk_checker u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .errors        (errors),
    .results_due   (results_due),
    .requests_seen (requests_seen),
    .results_seen  (results_seen),
    .walks_ok      (walks_ok),
    .walks_faulted (walks_faulted)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic logic [DATA_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic in_item_t translate_req(input logic [DATA_W-1:0] va);
    in_item_t req;
    req.opcode     = OP_TRANSLATE;
    req.virt_addr  = va;
    req.entry_data = rand64();
    return req;
  endfunction

  function automatic in_item_t entry_resp(input logic [DATA_W-1:0] pte);
    in_item_t req;
    req.opcode     = OP_DATA;
    req.virt_addr  = rand64();
    req.entry_data = pte;
    return req;
  endfunction

  function automatic logic [DATA_W-1:0] mapped_va();
    logic [DATA_W-1:0] va;
    va = rand64();
    va[DATA_W-1:VA_TOP] = '0;
    return va;
  endfunction

  function automatic logic [DATA_W-1:0] table_entry(input bit leaf);
    logic [DATA_W-1:0] pte;
    pte = rand64();
    if (leaf) begin
      pte[PTE_V_BIT] = ($urandom_range(9) != 0);
      pte[PTE_U_BIT] = ($urandom_range(6) != 0);
    end else begin
      pte[PTE_V_BIT] = ($urandom_range(19) != 0);
    end
    return pte;
  endfunction

  task automatic send_req(input in_item_t req);
    while ($urandom_range(99) < in_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_root(input logic [PPN_W-1:0] ppn);
    cfg_we    <= 1'b1;
    cfg_wdata <= ppn;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_random(input int unsigned n_reqs);
    int unsigned       sent;
    int unsigned       pick;
    int unsigned       depth;
    logic [DATA_W-1:0] va;
    sent = 0;
    while (sent < n_reqs) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        send_req(translate_req(mapped_va()));
        for (int k = 0; k < LEVELS; k++) send_req(entry_resp(table_entry(k == LEVELS - 1)));
        sent += LEVELS + 1;
      end else if (pick < 80) begin
        va = rand64();
        if (va[DATA_W-1:VA_TOP] == '0) va[$urandom_range(DATA_W - 1, VA_TOP)] = 1'b1;
        send_req(translate_req(va));
        sent++;
      end else if (pick < 90) begin
        send_req(entry_resp(rand64()));
        sent++;
      end else begin
        depth = $urandom_range(LEVELS - 1);
        send_req(translate_req(mapped_va()));
        for (int k = 0; k < depth; k++) send_req(entry_resp(table_entry(1'b0)));
        sent += depth + 1;
      end
    end
  endtask

  initial begin : receiver
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req && !hold_off_taken) begin
        hold_off_taken = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= out_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no request or result moved for %0d cycles", WATCHDOG_LIMIT);
        $display("tb: errors");
        $finish;
      end
    end
  end

  initial begin : stimulus
    rst_n        <= 1'b0;
    cfg_we       <= 1'b0;
    cfg_wdata    <= '0;
    in_valid     <= 1'b0;
    in_data      <= '0;
    hold_off_req <= 1'b0;
    in_gap_pct    = 36;
    out_stall_pct = 73;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_root('0);

    // idle data, full walk through a pointer with R/W/X set, busy translate
    send_req(entry_resp(64'h0));
    send_req(translate_req(64'h0));
    send_req(translate_req(64'h0000_0012_3456_7000));
    send_req(entry_resp(64'hFFC0_0000_0000_000F | (64'hFFF_FFFF_FFFF << PTE_PPN_LSB)));
    send_req(entry_resp(64'h1));
    send_req(entry_resp(64'hFFFF_FFFF_FFFF_FFFF));
    // range faults
    send_req(translate_req(64'h0000_0040_0000_0000));
    send_req(translate_req(64'hFFFF_FFFF_FFFF_FFFF));
    send_req(translate_req(64'h8000_0000_0000_0000));
    // top in-range address, invalid top-level entry
    send_req(translate_req(64'h0000_003F_FFFF_FFFF));
    send_req(entry_resp(64'hFFFF_FFFF_FFFF_FFFE));
    send_req(entry_resp(64'h1));
    // invalid middle entry
    send_req(translate_req(64'h0000_002A_AAAA_A000));
    send_req(entry_resp(64'h0000_0000_0000_0C01));
    send_req(entry_resp(64'h0000_0000_0000_0010));
    // invalid leaf
    send_req(translate_req(64'h0000_0015_5555_5000));
    send_req(entry_resp(64'h1));
    send_req(entry_resp(64'h1));
    send_req(entry_resp(64'h0000_0000_0000_0010));
    // leaf without user access
    send_req(translate_req(64'h0000_0000_0000_1000));
    send_req(entry_resp(64'h401));
    send_req(entry_resp(64'h401));
    send_req(entry_resp(64'hFFFF_FFFF_FFFF_FFEF));
    drain();

    write_root('1);
    run_random(380);
    drain();

    in_gap_pct    = 73;
    out_stall_pct = 36;
    write_root(PPN_W'(rand64()));
    run_random(380);
    drain();

    in_gap_pct    = 0;
    out_stall_pct = 0;
    write_root(PPN_W'(rand64()));
    hold_off_req <= 1'b1;
    run_random(390);
    drain();

    $display("summary: %0d requests accepted, %0d results checked, four root settings",
             requests_seen, results_seen);
    $display("summary: %0d walks mapped a page, %0d ended in a fault",
             walks_ok, walks_faulted);
    if (errors == 0 && results_due == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
